// ----- hw/rtl/bmes_pkg.sv -----
// Shared types and constants for the button matrix event scanner.
// No dependencies; imported by every module of the block.
package bmes_pkg;

  // Fixed field widths
  localparam int unsigned ScanW   = 40;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned PosW    = 3;
  localparam int unsigned DebW    = 8;

  // Default matrix size and register reset value
  localparam int unsigned RowsDef     = 5;
  localparam int unsigned ColsDef     = 8;
  localparam logic [DebW-1:0] DebounceRst = 8'd10;

  // One scan of the matrix
  typedef struct packed {
    logic [ScanW-1:0] scan_bits;
    logic [TimeW-1:0] now_ms;
  } in_t;

  // One press or release event
  typedef struct packed {
    logic [PosW-1:0]  event_row;
    logic [PosW-1:0]  event_col;
    logic             pressed;
    logic [HoldW-1:0] held_ms;
    logic             last_event;
  } out_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_VISIT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

endpackage

// ----- hw/rtl/bmes_press_mem.sv -----
// Press time store: one 16-bit time stamp per button.
// Depends on bmes_pkg; one write port, one registered read port.
module bmes_press_mem #(
  parameter int unsigned Depth = 40,
  parameter int unsigned AddrW = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          addr_i,
  input  logic [bmes_pkg::HoldW-1:0] wdata_i,
  output logic [bmes_pkg::HoldW-1:0] rdata_o
);
  import bmes_pkg::*;

  logic [HoldW-1:0] mem_q [Depth];
  logic [HoldW-1:0] rdata_q;

  // Write and registered read at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/button_matrix_event_scanner.sv -----
// Button matrix event scanner top level.
// Depends on bmes_pkg and bmes_press_mem.

// A scan transfer is taken only while the block is idle. A check state compares the
// debounce window against the last accepted scan; an ignored scan or a scan
// with no changes returns to idle right there. An accepted scan then walks the
// buttons one per cycle under a small sequencer, pausing at each changed button,
// rows from the top down and columns left to right, and stops after the last
// changed button. Each changed button passes through an emit state for the
// registered read of the press time store and stays there while the output waits
// on out_ready_i. A final visit confirms nothing is left before going back to
// idle. Results sit in an output register, so the final event may still wait
// there while the next scan is accepted. Config writes to debounce_ms are
// always taken.
module button_matrix_event_scanner #(
  parameter int unsigned ROWS = bmes_pkg::RowsDef,
  parameter int unsigned COLS = bmes_pkg::ColsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bmes_pkg::DebW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bmes_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bmes_pkg::out_t             out_data_o
);
  import bmes_pkg::*;

  localparam int unsigned N    = ROWS * COLS;
  localparam int unsigned IdxW = (N > 1) ? $clog2(N) : 1;

  state_e            state_q, state_d;
  logic [DebW-1:0]   debounce_q;
  logic [N-1:0]      btn_q;
  logic [N-1:0]      diff_q, diff_d;
  logic [N-1:0]      cur_bits;
  logic [TimeW-1:0]  last_scan_q;
  in_t               scan_q;
  logic [PosW-1:0]   row_q, row_d;
  logic [PosW-1:0]   col_q, col_d;
  logic              pressed_q, last_q;
  logic [6:0]        idx_wide;
  logic [IdxW-1:0]   idx;
  logic [N-1:0]      idx_mask;
  logic [TimeW-1:0]  elapsed;
  logic              accept_scan;
  logic [HoldW-1:0]  now16;
  logic [HoldW-1:0]  rd_data;
  logic              mem_we;
  logic              out_load;
  logic              out_valid_q;
  out_t              out_q;

  // Config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  // Scan bits mapped onto the matrix; positions past the input width read 0
  always_comb begin
    for (int unsigned i = 0; i < N; i++) begin
      cur_bits[i] = (i < ScanW) ? scan_q.scan_bits[i] : 1'b0;
    end
  end

  // Debounce window check
  assign elapsed     = scan_q.now_ms - last_scan_q;
  assign accept_scan = elapsed >= {{(TimeW-DebW){1'b0}}, debounce_q};
  assign now16       = scan_q.now_ms[HoldW-1:0];

  // Button position
  assign idx_wide = {4'b0, row_q} * 7'(COLS) + {4'b0, col_q};
  assign idx      = idx_wide[IdxW-1:0];
  assign idx_mask = N'(1) << idx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign mem_we     = (state_q == ST_VISIT) && diff_q[idx] && btn_q[idx];

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    diff_d  = diff_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        row_d  = PosW'(ROWS - 1);
        col_d  = '0;
        diff_d = cur_bits ^ btn_q;
        state_d = (accept_scan && (diff_d != '0)) ? ST_VISIT : ST_IDLE;
      end
      ST_VISIT: begin
        if (diff_q == '0) begin
          state_d = ST_IDLE;
        end else if (diff_q[idx]) begin
          state_d = ST_EMIT;
        end else if (col_q == PosW'(COLS - 1)) begin
          col_d = '0;
          row_d = row_q - PosW'(1);
        end else begin
          col_d = col_q + PosW'(1);
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          diff_d  = diff_q & ~idx_mask;
          state_d = ST_VISIT;
          if (col_q == PosW'(COLS - 1)) begin
            col_d = '0;
            row_d = row_q - PosW'(1);
          end else begin
            col_d = col_q + PosW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      btn_q       <= '0;
      last_scan_q <= '0;
      diff_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      diff_q  <= diff_d;
      if ((state_q == ST_CHECK) && accept_scan) begin
        btn_q       <= cur_bits;
        last_scan_q <= scan_q.now_ms;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    if (in_valid_i && in_ready_o) begin
      scan_q <= in_data_i;
    end
    if ((state_q == ST_VISIT) && diff_q[idx]) begin
      pressed_q <= btn_q[idx];
      last_q    <= (diff_q & ~idx_mask) == '0;
    end
    if (out_load) begin
      out_q.event_row  <= row_q;
      out_q.event_col  <= col_q;
      out_q.pressed    <= pressed_q;
      out_q.held_ms    <= pressed_q ? '0 : (now16 - rd_data);
      out_q.last_event <= last_q;
    end
  end

  // Press time store
  bmes_press_mem #(
    .Depth (N),
    .AddrW (IdxW)
  ) u_press_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (idx),
    .wdata_i (now16),
    .rdata_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/bmes_checker.sv -----
// Port-level checks for the button matrix event scanner.
// Depends on bmes_pkg; bound to the top level at the end of this file.
module bmes_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bmes_pkg::out_t out_data_o
);
  import bmes_pkg::*;

  // A waiting result stays until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output result dropped or changed while stalled");

  // A scan transfer makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("scan taken while busy");

  // New results only appear while a scan is being worked on
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result appeared while idle");

  // Press events carry no hold time
  a_press_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pressed |-> out_data_o.held_ms == '0)
    else $error("press event with nonzero hold time");

endmodule

bind button_matrix_event_scanner bmes_checker u_bmes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/tb_button_matrix_event_scanner.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for button_matrix_event_scanner.
// Feeds scans and debounce writes from a queue, predicts each press and release
// event, and checks results in order. Depends on bmes_pkg and the block's RTL.
module tb_button_matrix_event_scanner;
  import bmes_pkg::*;

  localparam int unsigned Rows         = RowsDef;
  localparam int unsigned Cols         = ColsDef;
  localparam int unsigned SettleCycles = 150;     // block may still walk an eventless scan
  localparam int unsigned DrainCycles  = 150;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned PhaseScans   = 35;      // random scans per phase
  localparam int unsigned ReportMax    = 10;
  localparam logic [ScanW-1:0] AllPressed = '1;

  typedef enum logic {OP_SCAN, OP_DEBOUNCE} op_kind_e;

  typedef struct {
    op_kind_e        kind;
    in_t             scan;
    logic [DebW-1:0] debounce;
    int unsigned     max_gap;
  } matrix_op_t;

  // DUT signals, all inputs known from time zero
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic [DebW-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  in_t             in_data_i   = '0;
  logic            out_ready_i = 1'b0;
  logic            cfg_ready_o;
  logic            in_ready_o;
  logic            out_valid_o;
  out_t            out_data_o;

  button_matrix_event_scanner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Stimulus and expectation stores
  matrix_op_t pending_ops[$];
  out_t       expected_events[$];

  // Predictor state
  logic [Cols-1:0]  btn_state [Rows];
  logic [HoldW-1:0] press_ms [Rows*Cols];
  logic [TimeW-1:0] last_accept_ms;
  logic [DebW-1:0]  debounce_model;

  // Transfer flags, set at the rising edge and read by the driver at the falling edge
  bit scan_taken, cfg_taken, event_taken;

  int unsigned max_gap      = 9;
  int unsigned scan_gap     = 0;
  int unsigned ready_hold   = 0;
  int unsigned settle_count = 0;
  int unsigned cycle_count  = 0;
  int unsigned errors       = 0;
  int unsigned scans_sent   = 0;
  int unsigned scans_passed = 0;
  int unsigned events_seen  = 0;
  int unsigned deb_writes   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the events one scan causes and queue them in order
  task automatic predict_events(input in_t scan);
    logic [TimeW-1:0] elapsed;
    logic [HoldW-1:0] now16;
    logic [Cols-1:0]  row_bits;
    out_t             ev;
    out_t             held_ev;
    bit               have_ev;
    int unsigned      idx;
    elapsed = scan.now_ms - last_accept_ms;
    now16   = scan.now_ms[HoldW-1:0];
    have_ev = 1'b0;
    held_ev = '0;
    ev      = '0;
    if (elapsed < debounce_model) return;
    scans_passed++;
    // top row first, columns left to right
    for (int r = Rows - 1; r >= 0; r--) begin
      row_bits = scan.scan_bits[r*Cols +: Cols];
      for (int c = 0; c < Cols; c++) begin
        if (row_bits[c] != btn_state[r][c]) begin
          idx           = r * Cols + c;
          ev.event_row  = PosW'(r);
          ev.event_col  = PosW'(c);
          ev.pressed    = row_bits[c];
          ev.last_event = 1'b0;
          if (row_bits[c]) begin
            press_ms[idx] = now16;
            ev.held_ms    = '0;
          end else begin
            ev.held_ms = now16 - press_ms[idx];
          end
          // hold one back so the final one can be marked
          if (have_ev) expected_events.push_back(held_ev);
          held_ev = ev;
          have_ev = 1'b1;
        end
      end
      btn_state[r] = row_bits;
    end
    if (have_ev) begin
      held_ev.last_event = 1'b1;
      expected_events.push_back(held_ev);
    end
    last_accept_ms = scan.now_ms;
  endtask

  task automatic add_scan(input logic [ScanW-1:0] bits, input logic [TimeW-1:0] ms);
    matrix_op_t op;
    op.kind           = OP_SCAN;
    op.scan.scan_bits = bits;
    op.scan.now_ms    = ms;
    op.debounce       = '0;
    op.max_gap        = 0;
    pending_ops.push_back(op);
  endtask

  // Debounce write; also sets how hard both sides idle from here on
  task automatic add_debounce(input logic [DebW-1:0] value, input int unsigned gap);
    matrix_op_t op;
    op.kind     = OP_DEBOUNCE;
    op.scan     = '0;
    op.debounce = value;
    op.max_gap  = gap;
    pending_ops.push_back(op);
  endtask

  // Monitor: record transfers, check events, feed the predictor
  always @(posedge clk_i) begin
    out_t got;
    out_t want;
    scan_taken  = rst_ni && in_valid_i && in_ready_o;
    cfg_taken   = rst_ni && cfg_valid_i && cfg_ready_o;
    event_taken = rst_ni && out_valid_o && out_ready_i;
    if (event_taken) begin
      got = out_data_o;
      events_seen++;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("%0t: event with none expected: row %0d col %0d pressed %0d held %0d last %0d",
                   $time, got.event_row, got.event_col, got.pressed, got.held_ms,
                   got.last_event);
      end else begin
        want = expected_events.pop_front();
        if (got.event_row !== want.event_row || got.event_col !== want.event_col ||
            got.pressed !== want.pressed || got.held_ms !== want.held_ms ||
            got.last_event !== want.last_event) begin
          errors++;
          if (errors <= ReportMax) begin
            $display("%0t: event mismatch", $time);
            $display("  expected row %0d col %0d pressed %0d held %0d last %0d",
                     want.event_row, want.event_col, want.pressed, want.held_ms,
                     want.last_event);
            $display("  actual   row %0d col %0d pressed %0d held %0d last %0d",
                     got.event_row, got.event_col, got.pressed, got.held_ms,
                     got.last_event);
          end
        end
      end
    end
    if (cfg_taken) begin
      debounce_model = cfg_data_i;
      deb_writes++;
    end
    if (scan_taken) begin
      scans_sent++;
      predict_events(in_data_i);
    end
  end

  // Driver: scans and debounce writes in queue order, plus output backpressure
  always @(negedge clk_i) begin
    logic            nxt_in_valid;
    logic            nxt_cfg_valid;
    logic            nxt_ready;
    in_t             nxt_in_data;
    logic [DebW-1:0] nxt_cfg_data;
    matrix_op_t      op;
    nxt_in_valid  = in_valid_i;
    nxt_cfg_valid = cfg_valid_i;
    nxt_ready     = out_ready_i;
    nxt_in_data   = in_data_i;
    nxt_cfg_data  = cfg_data_i;
    if (rst_ni) begin
      if (scan_taken) begin
        nxt_in_valid = 1'b0;
        scan_gap     = $urandom_range(0, max_gap);
      end
      if (cfg_taken) nxt_cfg_valid = 1'b0;
      if (!nxt_in_valid && !nxt_cfg_valid && pending_ops.size() != 0) begin
        op = pending_ops[0];
        if (op.kind == OP_SCAN) begin
          if (scan_gap != 0) begin
            scan_gap--;
          end else begin
            void'(pending_ops.pop_front());
            nxt_in_valid = 1'b1;
            nxt_in_data  = op.scan;
          end
        end else if (expected_events.size() != 0) begin
          settle_count = 0;
        end else if (settle_count < SettleCycles) begin
          // let the block finish any scan that produced nothing
          settle_count++;
        end else begin
          void'(pending_ops.pop_front());
          nxt_cfg_valid = 1'b1;
          nxt_cfg_data  = op.debounce;
          max_gap       = op.max_gap;
          settle_count  = 0;
        end
      end
      // receiver stall, drawn once per event
      if (event_taken) ready_hold = $urandom_range(0, max_gap);
      if (ready_hold != 0) begin
        nxt_ready = 1'b0;
        ready_hold--;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    in_valid_i  <= nxt_in_valid;
    in_data_i   <= nxt_in_data;
    cfg_valid_i <= nxt_cfg_valid;
    cfg_data_i  <= nxt_cfg_data;
    out_ready_i <= nxt_ready;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d events still expected", cycle_count,
               expected_events.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Reset, stimulus and end of run
  initial begin
    logic [DebW-1:0]  deb;
    logic [TimeW-1:0] gen_now;
    logic [ScanW-1:0] gen_bits;
    int unsigned      pick;
    int unsigned      flips;
    int unsigned      bit_idx;
    int unsigned      gap;

    for (int r = 0; r < Rows; r++) btn_state[r] = '0;
    for (int i = 0; i < Rows * Cols; i++) press_ms[i] = '0;
    last_accept_ms = '0;
    debounce_model = DebounceRst;

    // Directed: debounce at its reset value, boundaries measured from time zero
    add_scan(AllPressed, 32'd5);                 // too soon after reset
    add_scan(AllPressed, 32'd9);                 // one short of the window
    add_scan(AllPressed, 32'd10);                // exactly on it: every button pressed
    add_scan('0, 32'd19);                        // ignored
    add_scan(AllPressed, 32'd20);                // accepted, nothing changed
    add_scan('0, 32'h0001_0005);                 // all released, hold time wraps
    add_scan(40'h80_0000_0001, 32'h0001_0100);   // corner buttons pressed
    add_scan(40'h00_0000_0001, 32'h0002_0000);   // top corner released
    add_scan(40'hAA_AAAA_AAAA, 32'hFFFF_FFF6);
    add_scan(40'h55_5555_5555, 32'h0000_0000);   // elapsed wraps through zero
    add_scan('0, 32'h0000_0009);                 // elapsed 9, ignored
    add_scan(40'hFF_0000_00FF, 32'hFFFF_FFFF);
    // Debounce off, no idling: equal timestamps still pass
    add_debounce(8'd0, 0);
    add_scan(40'h00_0000_000F, 32'hFFFF_FFFF);
    add_scan(40'h00_0000_00F0, 32'hFFFF_FFFF);
    add_scan(40'h80_0000_0000, 32'h0000_0000);
    // Longest window
    add_debounce(8'd255, 9);
    add_scan(AllPressed, 32'd254);
    add_scan(AllPressed, 32'd255);
    add_scan('0, 32'd509);
    add_scan('0, 32'd510);
    gen_now  = 32'd510;
    gen_bits = '0;

    // Random phases: mostly plausible scan sequences, some jumps and noise
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin deb = 8'($urandom_range(1, 254)); gap = 9; end
        1: begin deb = 8'($urandom_range(1, 254)); gap = 0; end
        2: begin deb = 8'd0;                       gap = 9; end
        default: begin deb = 8'd255;               gap = 9; end
      endcase
      add_debounce(deb, gap);
      for (int i = 0; i < PhaseScans; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)       gen_now = $urandom;
        else if (pick < 25) gen_now = gen_now + $urandom_range(0, deb);
        else                gen_now = gen_now + deb + $urandom_range(0, 40);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          gen_bits = '0;
        end else if (pick < 15) begin
          gen_bits = AllPressed;
        end else if (pick < 35) begin
          gen_bits = {8'($urandom), $urandom};
        end else begin
          // a few buttons change between scans
          flips = $urandom_range(1, 4);
          for (int f = 0; f < flips; f++) begin
            bit_idx           = $urandom_range(0, ScanW - 1);
            gen_bits[bit_idx] = ~gen_bits[bit_idx];
          end
        end
        add_scan(gen_bits, gen_now);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_i || cfg_valid_i) @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    errors += expected_events.size();

    $display("Ran %0d scans (%0d past the debounce window) and %0d debounce writes,",
             scans_sent, scans_passed, deb_writes);
    $display("checking %0d press/release events under random stalls on both sides.",
             events_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bmes_pkg.sv
hw/rtl/bmes_press_mem.sv
hw/rtl/button_matrix_event_scanner.sv
hw/rtl/bmes_checker.sv
tb/tb_button_matrix_event_scanner.sv
